[rtl/core/nls_pkg.sv]
// shared types, constants and codes for the natural log series block
// no dependencies
`timescale 1ns / 1ps

package nls_pkg;

  localparam int NLS_MAX_TERMS      = 4096;
  localparam int NLS_STOP_FRAC_BITS = 24;

  localparam int XW     = 32;  // input argument, Q16.16
  localparam int LNW    = 32;  // result, Q8.24
  localparam int TUW    = 13;  // terms used field
  localparam int STW    = 2;   // status field
  localparam int FRAC   = 30;  // ratio and power fraction bits
  localparam int PROD_W = 2 * FRAC;

  // divider widths: remainder and divisor cover x + 1.0 in Q16.16
  localparam int DVW    = XW + 1;
  localparam int QW     = FRAC + 1;
  localparam int CNTW   = 5;

  localparam logic [XW-1:0] ONE_Q16 = XW'(65536);
  localparam logic [CNTW-1:0] RATIO_STEPS = CNTW'(FRAC);
  localparam logic [CNTW-1:0] TERM_STEPS  = CNTW'(QW);

  typedef enum logic [STW-1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_CAP  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_RDIV,
    SEQ_SQR,
    SEQ_R2,
    SEQ_TSTART,
    SEQ_TDIV,
    SEQ_PMUL,
    SEQ_PNEW,
    SEQ_DONE
  } seq_state_e;

  typedef struct packed {
    logic            start;
    logic [CNTW-1:0] steps;
    logic [DVW-1:0]  rem_init;
    logic [QW-1:0]   dividend;
    logic [DVW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic [LNW-1:0] ln;
    logic [TUW-1:0] terms;
    status_e        status;
  } seq_res_t;

endpackage

[rtl/core/nls_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
// depends on nls_pkg
`timescale 1ns / 1ps

module nls_div
  import nls_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [DVW-1:0]  rem_q, rem_d;
  logic [DVW-1:0]  divisor_q, divisor_d;
  logic [QW-1:0]   dvd_q, dvd_d;
  logic [QW-1:0]   quot_q, quot_d;
  logic [DVW:0]    trial;
  logic [DVW:0]    diff;
  logic            fits;

  assign trial = {rem_q, dvd_q[QW-1]};
  assign diff  = trial - {1'b0, divisor_q};
  assign fits  = (trial >= {1'b0, divisor_q});

  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    dvd_d     = dvd_q;
    quot_d    = quot_q;
    if (req_i.start) begin
      busy_d    = 1'b1;
      cnt_d     = req_i.steps;
      rem_d     = req_i.rem_init;
      divisor_d = req_i.divisor;
      dvd_d     = req_i.dividend;
      quot_d    = '0;
    end else if (busy_q) begin
      rem_d  = fits ? diff[DVW-1:0] : trial[DVW-1:0];
      dvd_d  = {dvd_q[QW-2:0], 1'b0};
      quot_d = {quot_q[QW-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
    dvd_q     <= dvd_d;
    quot_q    <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < divisor_q))
    else $error("partial remainder not below divisor");

  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> done_q)
    else $error("divider finished without done pulse");
`endif

endmodule

[rtl/core/nls_seq.sv]
// sequencer and datapath: ratio, odd powers, term division and the running sum
// depends on nls_pkg and drives the shared nls_div unit
`timescale 1ns / 1ps

module nls_seq
  import nls_pkg::*;
#(
  parameter int MAX_TERMS      = NLS_MAX_TERMS,
  parameter int STOP_FRAC_BITS = NLS_STOP_FRAC_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [XW-1:0] x_i,
  output logic          idle_o,
  output logic          res_valid_o,
  input  logic          res_take_i,
  output seq_res_t      res_o,
  output div_req_t      div_req_o,
  input  div_rsp_t      div_rsp_i
);

  localparam int KW  = $clog2(MAX_TERMS + 1);
  localparam int TSH = FRAC - STOP_FRAC_BITS;
  localparam logic [KW-1:0] K_CAP = KW'(MAX_TERMS);

  seq_state_e state_q, state_d;

  logic            neg_q;
  logic [FRAC-1:0] pmag_q;
  logic [FRAC-1:0] r2_q;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [FRAC-1:0] mul_b;
  logic [LNW-1:0]  sum_q;
  logic [KW-1:0]   k_q;
  logic [KW-1:0]   k_next;
  status_e         status_q;

  logic            x_neg;
  logic [XW-1:0]   x_dist;
  logic [QW-1:0]   tmag;
  logic            negligible;
  logic [LNW-1:0]  t_rnd;
  logic [LNW-1:0]  t24;
  logic [31:0]     k_ext;

  assign x_neg      = (x_i < ONE_Q16);
  assign x_dist     = x_neg ? (ONE_Q16 - x_i) : (x_i - ONE_Q16);
  assign tmag       = div_rsp_i.quot;
  assign negligible = ((tmag >> TSH) == '0);
  assign t_rnd      = LNW'(tmag) + LNW'(32);
  assign t24        = t_rnd >> 6;
  assign k_next     = k_q + 1'b1;
  assign k_ext      = 32'(k_q);

  // shared multiplier: squares r first, then steps the odd power
  assign mul_b  = (state_q == SEQ_SQR) ? pmag_q : r2_q;
  assign prod_d = pmag_q * mul_b;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEQ_IDLE: begin
        if (start_i) state_d = (x_i == '0) ? SEQ_DONE : SEQ_RDIV;
      end
      SEQ_RDIV: begin
        if (div_rsp_i.done) state_d = SEQ_SQR;
      end
      SEQ_SQR:    state_d = SEQ_R2;
      SEQ_R2:     state_d = SEQ_TSTART;
      SEQ_TSTART: state_d = SEQ_TDIV;
      SEQ_TDIV: begin
        if (div_rsp_i.done) begin
          if (negligible || (k_next == K_CAP)) state_d = SEQ_DONE;
          else state_d = SEQ_PMUL;
        end
      end
      SEQ_PMUL:   state_d = SEQ_PNEW;
      SEQ_PNEW:   state_d = SEQ_TSTART;
      SEQ_DONE: begin
        if (res_take_i) state_d = SEQ_IDLE;
      end
      default:    state_d = SEQ_IDLE;
    endcase
  end

  always_comb begin
    div_req_o = '0;
    unique case (state_q)
      SEQ_IDLE: begin
        // r = |x - 1| * 2^30 / (x + 1): remainder starts at |x - 1|
        div_req_o.start    = start_i && (x_i != '0);
        div_req_o.steps    = RATIO_STEPS;
        div_req_o.rem_init = DVW'(x_dist);
        div_req_o.divisor  = DVW'(x_i) + DVW'(ONE_Q16);
      end
      SEQ_TSTART: begin
        div_req_o.start    = 1'b1;
        div_req_o.steps    = TERM_STEPS;
        div_req_o.dividend = {pmag_q, 1'b0};
        div_req_o.divisor  = DVW'({k_q, 1'b1});
      end
      default: div_req_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SEQ_IDLE;
      sum_q    <= '0;
      k_q      <= '0;
      status_q <= ST_OK;
    end else begin
      state_q <= state_d;
      if (state_q == SEQ_IDLE && start_i) begin
        sum_q    <= '0;
        k_q      <= '0;
        status_q <= (x_i == '0) ? ST_ZERO : ST_CAP;
      end
      if (state_q == SEQ_TDIV && div_rsp_i.done) begin
        if (negligible) begin
          status_q <= ST_OK;
        end else begin
          sum_q <= neg_q ? (sum_q - t24) : (sum_q + t24);
          k_q   <= k_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SEQ_IDLE && start_i) neg_q <= x_neg;
    if (state_q == SEQ_RDIV && div_rsp_i.done) pmag_q <= div_rsp_i.quot[FRAC-1:0];
    if (state_q == SEQ_SQR || state_q == SEQ_PMUL) prod_q <= prod_d;
    if (state_q == SEQ_R2) r2_q <= prod_q[PROD_W-1:FRAC];
    if (state_q == SEQ_PNEW) pmag_q <= prod_q[PROD_W-1:FRAC];
  end

  assign idle_o       = (state_q == SEQ_IDLE);
  assign res_valid_o  = (state_q == SEQ_DONE);
  assign res_o.ln     = sum_q;
  assign res_o.terms  = k_ext[TUW-1:0];
  assign res_o.status = status_q;

`ifndef NO_ASSERTIONS
  a_k_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= K_CAP)
    else $error("term counter passed the cap");
`endif

endmodule

[rtl/core/natural_log_series_top.sv]
// top level of the natural log series block: handshakes and result register
// depends on nls_pkg, nls_div and nls_seq
`timescale 1ns / 1ps

// Computes ln(x) for an unsigned Q16.16 argument and returns it in signed Q8.24,
// with the count of atanh series terms summed and a status (0 ok, 1 zero argument,
// 2 term cap reached). One transaction is worked on at a time; in_stall_o is high
// from acceptance until the result has been moved into the output register, which
// can still be waiting for the consumer while the next argument is taken. A zero
// argument skips the divider. Otherwise the ratio and every series term, including a
// final negligible one, each take a division on the bit-serial divider, which makes
// one quotient bit per cycle and is shared between the ratio and term divisions.
module natural_log_series_top
  import nls_pkg::*;
#(
  parameter int MAX_TERMS      = NLS_MAX_TERMS,
  parameter int STOP_FRAC_BITS = NLS_STOP_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [XW-1:0]         x_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [LNW-1:0] ln_value_o,
  output logic [TUW-1:0]        terms_used_o,
  output logic [STW-1:0]        status_o
);

  div_req_t div_req;
  div_rsp_t div_rsp;
  seq_res_t seq_res;
  seq_res_t res_q;
  logic     seq_idle;
  logic     res_valid;
  logic     res_take;
  logic     out_valid_q, out_valid_d;

  assign in_stall_o = !seq_idle;
  assign res_take   = !out_valid_q || !out_stall_i;

  nls_seq #(
    .MAX_TERMS      (MAX_TERMS),
    .STOP_FRAC_BITS (STOP_FRAC_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i),
    .x_i         (x_value_i),
    .idle_o      (seq_idle),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (seq_res),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

  nls_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_take) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_take) res_q <= seq_res;
  end

  assign out_valid_o  = out_valid_q;
  assign ln_value_o   = res_q.ln;
  assign terms_used_o = res_q.terms;
  assign status_o     = res_q.status;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block ready again right after a transaction");
`endif

endmodule
